/* design/circle_fit_least_squares_core_assert.svh */
// assertion macros for the circle fit core
// used by circle_fit_least_squares_core.sv; no other dependencies
`ifndef CIRCLE_FIT_LEAST_SQUARES_CORE_ASSERT_SVH
`define CIRCLE_FIT_LEAST_SQUARES_CORE_ASSERT_SVH

// same-cycle implication
`define CLFIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clfit assertion failed");

// next-cycle implication
`define CLFIT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clfit assertion failed");

`endif

/* design/clfit_pkg.sv */
// types, constants and the solve microprogram of the circle fit core
// no dependencies
`timescale 1ns / 1ps

package clfit_pkg;

  localparam int WIDE_W = 144;
  localparam int ITER_W = $clog2(WIDE_W + 1);
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 31;
  localparam int CTR_W  = 32;
  localparam int PC_W   = 6;

  typedef enum logic [3:0] {
    OP_LOAD, OP_MUL, OP_ADD, OP_SUB, OP_ABS, OP_MAX0, OP_DIV,
    OP_HALF, OP_ROOT, OP_FAIL, OP_BRNP, OP_END
  } op_e;

  typedef enum logic [4:0] {
    R_N, R_SX, R_SY, R_SZ, R_SXX, R_SXY, R_SYY, R_SXZ, R_SYZ,
    R_CXX, R_CXY, R_CYY, R_CXZ, R_CYZ, R_DET, R_DN, R_EN,
    R_CX, R_CY, R_Q, R_T0, R_T1, R_T2
  } reg_e;

  typedef struct packed {
    op_e  op;
    reg_e rd;
    reg_e ra;
    reg_e rb;
  } instr_t;

  typedef struct packed {
    logic   valid;
    instr_t instr;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic nonpos;
  } dp_status_t;

  localparam logic [PC_W-1:0] PC_FAIL = 6'd59;

  function automatic instr_t mk(op_e op, reg_e rd, reg_e ra, reg_e rb);
    instr_t i;
    i.op = op;
    i.rd = rd;
    i.ra = ra;
    i.rb = rb;
    return i;
  endfunction

  // solve sequence: reduce to 2x2 form, centre, then rms radius
  function automatic instr_t prog_rom(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = mk(OP_LOAD, R_N,   R_N,   R_N);
      6'd1:  i = mk(OP_LOAD, R_SX,  R_N,   R_N);
      6'd2:  i = mk(OP_LOAD, R_SY,  R_N,   R_N);
      6'd3:  i = mk(OP_LOAD, R_SZ,  R_N,   R_N);
      6'd4:  i = mk(OP_LOAD, R_SXX, R_N,   R_N);
      6'd5:  i = mk(OP_LOAD, R_SXY, R_N,   R_N);
      6'd6:  i = mk(OP_LOAD, R_SYY, R_N,   R_N);
      6'd7:  i = mk(OP_LOAD, R_SXZ, R_N,   R_N);
      6'd8:  i = mk(OP_LOAD, R_SYZ, R_N,   R_N);
      6'd9:  i = mk(OP_MUL,  R_T0,  R_N,   R_SXX);
      6'd10: i = mk(OP_MUL,  R_T1,  R_SX,  R_SX);
      6'd11: i = mk(OP_SUB,  R_CXX, R_T0,  R_T1);
      6'd12: i = mk(OP_MUL,  R_T0,  R_N,   R_SXY);
      6'd13: i = mk(OP_MUL,  R_T1,  R_SX,  R_SY);
      6'd14: i = mk(OP_SUB,  R_CXY, R_T0,  R_T1);
      6'd15: i = mk(OP_MUL,  R_T0,  R_N,   R_SYY);
      6'd16: i = mk(OP_MUL,  R_T1,  R_SY,  R_SY);
      6'd17: i = mk(OP_SUB,  R_CYY, R_T0,  R_T1);
      6'd18: i = mk(OP_MUL,  R_T0,  R_N,   R_SXZ);
      6'd19: i = mk(OP_MUL,  R_T1,  R_SX,  R_SZ);
      6'd20: i = mk(OP_SUB,  R_CXZ, R_T0,  R_T1);
      6'd21: i = mk(OP_MUL,  R_T0,  R_N,   R_SYZ);
      6'd22: i = mk(OP_MUL,  R_T1,  R_SY,  R_SZ);
      6'd23: i = mk(OP_SUB,  R_CYZ, R_T0,  R_T1);
      6'd24: i = mk(OP_MUL,  R_T0,  R_CXX, R_CYY);
      6'd25: i = mk(OP_MUL,  R_T1,  R_CXY, R_CXY);
      6'd26: i = mk(OP_SUB,  R_DET, R_T0,  R_T1);
      6'd27: i = mk(OP_BRNP, R_N,   R_N,   R_N);
      6'd28: i = mk(OP_MUL,  R_T0,  R_CXZ, R_CYY);
      6'd29: i = mk(OP_MUL,  R_T1,  R_CXY, R_CYZ);
      6'd30: i = mk(OP_SUB,  R_DN,  R_T0,  R_T1);
      6'd31: i = mk(OP_MUL,  R_T0,  R_CXX, R_CYZ);
      6'd32: i = mk(OP_MUL,  R_T1,  R_CXY, R_CXZ);
      6'd33: i = mk(OP_SUB,  R_EN,  R_T0,  R_T1);
      6'd34: i = mk(OP_ADD,  R_T2,  R_DET, R_DET);
      6'd35: i = mk(OP_ABS,  R_T0,  R_DN,  R_N);
      6'd36: i = mk(OP_ADD,  R_T0,  R_T0,  R_DET);
      6'd37: i = mk(OP_DIV,  R_T0,  R_T0,  R_T2);
      6'd38: i = mk(OP_HALF, R_CX,  R_T0,  R_DN);
      6'd39: i = mk(OP_ABS,  R_T0,  R_EN,  R_N);
      6'd40: i = mk(OP_ADD,  R_T0,  R_T0,  R_DET);
      6'd41: i = mk(OP_DIV,  R_T0,  R_T0,  R_T2);
      6'd42: i = mk(OP_HALF, R_CY,  R_T0,  R_EN);
      6'd43: i = mk(OP_MUL,  R_T0,  R_CX,  R_SX);
      6'd44: i = mk(OP_MUL,  R_T1,  R_CY,  R_SY);
      6'd45: i = mk(OP_ADD,  R_T0,  R_T0,  R_T1);
      6'd46: i = mk(OP_ADD,  R_T0,  R_T0,  R_T0);
      6'd47: i = mk(OP_SUB,  R_Q,   R_SZ,  R_T0);
      6'd48: i = mk(OP_MUL,  R_T0,  R_CX,  R_CX);
      6'd49: i = mk(OP_MUL,  R_T1,  R_CY,  R_CY);
      6'd50: i = mk(OP_ADD,  R_T0,  R_T0,  R_T1);
      6'd51: i = mk(OP_MUL,  R_T0,  R_N,   R_T0);
      6'd52: i = mk(OP_ADD,  R_Q,   R_Q,   R_T0);
      6'd53: i = mk(OP_MAX0, R_Q,   R_Q,   R_N);
      6'd54: i = mk(OP_ADD,  R_Q,   R_Q,   R_Q);
      6'd55: i = mk(OP_ADD,  R_Q,   R_Q,   R_Q);
      6'd56: i = mk(OP_DIV,  R_T0,  R_Q,   R_N);
      6'd57: i = mk(OP_ROOT, R_T1,  R_T0,  R_N);
      6'd58: i = mk(OP_END,  R_N,   R_N,   R_N);
      6'd59: i = mk(OP_FAIL, R_N,   R_N,   R_N);
      default: i = mk(OP_END, R_N,  R_N,   R_N);
    endcase
    return i;
  endfunction

endpackage

/* design/clfit_accum.sv */
// point accumulator: three-stage pipeline into the point count and eight running sums
// no dependencies
`timescale 1ns / 1ps

module clfit_accum #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  localparam int CNT_W  = $clog2(MAX_POINTS + 1),
  localparam int SX_W   = COORD_BITS + CNT_W,
  localparam int P_W    = 2 * COORD_BITS,
  localparam int SXX_W  = P_W + CNT_W,
  localparam int Z_W    = 2 * COORD_BITS + 1,
  localparam int SZ_W   = Z_W + CNT_W,
  localparam int XZ_W   = 3 * COORD_BITS + 1,
  localparam int SXZ_W  = XZ_W + CNT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic signed [15:0]      point_x_i,
  input  logic signed [15:0]      point_y_i,
  input  logic                    clear_i,
  output logic [CNT_W-1:0]        count_o,
  output logic signed [SX_W-1:0]  sum_x_o,
  output logic signed [SX_W-1:0]  sum_y_o,
  output logic signed [SXX_W-1:0] sum_xx_o,
  output logic signed [SXX_W-1:0] sum_xy_o,
  output logic signed [SXX_W-1:0] sum_yy_o,
  output logic signed [SXZ_W-1:0] sum_xz_o,
  output logic signed [SXZ_W-1:0] sum_yz_o,
  output logic signed [SZ_W-1:0]  sum_z_o
);

  logic [CNT_W-1:0]            count_q;
  logic                        v0_q, v1_q;
  logic signed [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
  logic signed [P_W-1:0]       xx1_q, xy1_q, yy1_q;
  logic signed [Z_W-1:0]       z2;
  logic signed [XZ_W-1:0]      xz2, yz2;
  logic                        take;

  logic signed [SX_W-1:0]  sum_x_q, sum_y_q;
  logic signed [SXX_W-1:0] sum_xx_q, sum_xy_q, sum_yy_q;
  logic signed [SXZ_W-1:0] sum_xz_q, sum_yz_q;
  logic signed [SZ_W-1:0]  sum_z_q;

  // points beyond the limit are dropped
  assign take = accept_i && (count_q < CNT_W'(MAX_POINTS));

  assign z2  = Z_W'(xx1_q) + Z_W'(yy1_q);
  assign xz2 = XZ_W'(x1_q) * XZ_W'(z2);
  assign yz2 = XZ_W'(y1_q) * XZ_W'(z2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
    end else begin
      v0_q <= take;
      v1_q <= v0_q;
      if (clear_i) begin
        count_q <= '0;
      end else if (take) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q  <= point_x_i[COORD_BITS-1:0];
    y0_q  <= point_y_i[COORD_BITS-1:0];
    x1_q  <= x0_q;
    y1_q  <= y0_q;
    xx1_q <= P_W'(x0_q) * P_W'(x0_q);
    xy1_q <= P_W'(x0_q) * P_W'(y0_q);
    yy1_q <= P_W'(y0_q) * P_W'(y0_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
      sum_yy_q <= '0;
      sum_xz_q <= '0;
      sum_yz_q <= '0;
      sum_z_q  <= '0;
    end else if (clear_i) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
      sum_yy_q <= '0;
      sum_xz_q <= '0;
      sum_yz_q <= '0;
      sum_z_q  <= '0;
    end else if (v1_q) begin
      sum_x_q  <= sum_x_q + SX_W'(x1_q);
      sum_y_q  <= sum_y_q + SX_W'(y1_q);
      sum_xx_q <= sum_xx_q + SXX_W'(xx1_q);
      sum_xy_q <= sum_xy_q + SXX_W'(xy1_q);
      sum_yy_q <= sum_yy_q + SXX_W'(yy1_q);
      sum_xz_q <= sum_xz_q + SXZ_W'(xz2);
      sum_yz_q <= sum_yz_q + SXZ_W'(yz2);
      sum_z_q  <= sum_z_q + SZ_W'(z2);
    end
  end

  assign count_o  = count_q;
  assign sum_x_o  = sum_x_q;
  assign sum_y_o  = sum_y_q;
  assign sum_xx_o = sum_xx_q;
  assign sum_xy_o = sum_xy_q;
  assign sum_yy_o = sum_yy_q;
  assign sum_xz_o = sum_xz_q;
  assign sum_yz_o = sum_yz_q;
  assign sum_z_o  = sum_z_q;

endmodule

/* design/clfit_dp.sv */
// solve datapath: wide register file, bit-serial multiply/divide/root unit
// depends on clfit_pkg
`timescale 1ns / 1ps

module clfit_dp import clfit_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  localparam int CNT_W  = $clog2(MAX_POINTS + 1),
  localparam int SX_W   = COORD_BITS + CNT_W,
  localparam int SXX_W  = 2 * COORD_BITS + CNT_W,
  localparam int SZ_W   = 2 * COORD_BITS + 1 + CNT_W,
  localparam int SXZ_W  = 3 * COORD_BITS + 1 + CNT_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [SX_W-1:0]          sum_x_i,
  input  logic [SX_W-1:0]          sum_y_i,
  input  logic [SXX_W-1:0]         sum_xx_i,
  input  logic [SXX_W-1:0]         sum_xy_i,
  input  logic [SXX_W-1:0]         sum_yy_i,
  input  logic [SXZ_W-1:0]         sum_xz_i,
  input  logic [SXZ_W-1:0]         sum_yz_i,
  input  logic [SZ_W-1:0]          sum_z_i,
  output logic signed [CTR_W-1:0]  center_x_o,
  output logic signed [CTR_W-1:0]  center_y_o,
  output logic [RAD_W-1:0]         radius_o,
  output logic                     fit_failed_o
);

  localparam int NREG = 1 << $bits(reg_e);
  localparam int SQ_W = 2 * ROOT_W + 4;

  typedef enum logic [1:0] {PH_IDLE, PH_EXEC, PH_RUN} ph_e;

  logic [WIDE_W-1:0] rf_q [NREG];
  logic [WIDE_W-1:0] opa_q, opb_q;

  ph_e               ph_q, ph_d;
  op_e               op_q;
  reg_e              rd_q;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [WIDE_W-1:0] a_q, a_d, b_q, b_d;
  logic [WIDE_W:0]   acc_q, acc_d;
  logic              sat_q, sat_d, nonpos_q, nonpos_d, done_q, done_d;
  logic [CTR_W-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [RAD_W-1:0]  rad_q, rad_d;

  logic              wr_en;
  logic [WIDE_W-1:0] wr_data;
  logic [WIDE_W-1:0] load_val;

  // one step of each serial operation
  logic [WIDE_W-1:0] mul_acc;
  logic [WIDE_W:0]   div_sh, div_rem;
  logic              div_ge;
  logic [WIDE_W-1:0] div_a;
  logic [SQ_W-1:0]   sq_sh, sq_trial, sq_rem;
  logic              sq_ge;
  logic [WIDE_W-1:0] sq_root;
  logic [ROOT_W:0]   rad_sum;
  logic [ROOT_W-1:0] rad_r;

  // centre finishing: round-half quotient, saturate, restore sign
  logic              h_neg, h_over;
  logic [63:0]       h_lim, h_v;
  logic [WIDE_W-1:0] h_ext, half_val;

  assign mul_acc = acc_q[WIDE_W-1:0] + (b_q[0] ? a_q : '0);

  assign div_sh  = {acc_q[WIDE_W-1:0], a_q[WIDE_W-1]};
  assign div_ge  = div_sh >= {1'b0, b_q};
  assign div_rem = div_ge ? (div_sh - {1'b0, b_q}) : div_sh;
  assign div_a   = {a_q[WIDE_W-2:0], div_ge};

  assign sq_sh    = {acc_q[SQ_W-3:0], a_q[63:62]};
  assign sq_trial = {2'b00, b_q[ROOT_W-1:0], 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;
  assign sq_root  = {b_q[WIDE_W-2:0], sq_ge};
  assign rad_sum  = {1'b0, sq_root[ROOT_W-1:0]} + (ROOT_W + 1)'(1);
  assign rad_r    = rad_sum[ROOT_W:1];

  assign h_neg    = opb_q[WIDE_W-1];
  assign h_lim    = h_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
  assign h_over   = (|opa_q[WIDE_W-1:64]) || (opa_q[63:0] > h_lim);
  assign h_v      = h_over ? h_lim : opa_q[63:0];
  assign h_ext    = {{(WIDE_W-64){1'b0}}, h_v};
  assign half_val = h_neg ? (WIDE_W'(0) - h_ext) : h_ext;

  always_comb begin
    case (rd_q)
      R_N:     load_val = {{(WIDE_W-CNT_W){1'b0}}, count_i};
      R_SX:    load_val = {{(WIDE_W-SX_W){sum_x_i[SX_W-1]}}, sum_x_i};
      R_SY:    load_val = {{(WIDE_W-SX_W){sum_y_i[SX_W-1]}}, sum_y_i};
      R_SZ:    load_val = {{(WIDE_W-SZ_W){sum_z_i[SZ_W-1]}}, sum_z_i};
      R_SXX:   load_val = {{(WIDE_W-SXX_W){sum_xx_i[SXX_W-1]}}, sum_xx_i};
      R_SXY:   load_val = {{(WIDE_W-SXX_W){sum_xy_i[SXX_W-1]}}, sum_xy_i};
      R_SYY:   load_val = {{(WIDE_W-SXX_W){sum_yy_i[SXX_W-1]}}, sum_yy_i};
      R_SXZ:   load_val = {{(WIDE_W-SXZ_W){sum_xz_i[SXZ_W-1]}}, sum_xz_i};
      R_SYZ:   load_val = {{(WIDE_W-SXZ_W){sum_yz_i[SXZ_W-1]}}, sum_yz_i};
      default: load_val = '0;
    endcase
  end

  always_comb begin
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    cx_d    = cx_q;
    cy_d    = cy_q;
    rad_d   = rad_q;
    wr_en   = 1'b0;
    wr_data = opa_q;
    case (ph_q)
      PH_IDLE: begin
        if (cmd_i.valid) ph_d = PH_EXEC;
      end
      PH_EXEC: begin
        ph_d   = PH_IDLE;
        done_d = 1'b1;
        case (op_q)
          OP_LOAD: begin
            wr_en   = 1'b1;
            wr_data = load_val;
            sat_d   = 1'b0;
          end
          OP_MUL, OP_DIV: begin
            a_d    = opa_q;
            b_d    = opb_q;
            acc_d  = '0;
            cnt_d  = ITER_W'(WIDE_W);
            ph_d   = PH_RUN;
            done_d = 1'b0;
          end
          OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = opa_q + opb_q;
          end
          OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = opa_q - opb_q;
          end
          OP_ABS: begin
            wr_en   = 1'b1;
            wr_data = opa_q[WIDE_W-1] ? (WIDE_W'(0) - opa_q) : opa_q;
          end
          OP_MAX0: begin
            wr_en   = 1'b1;
            wr_data = opa_q[WIDE_W-1] ? '0 : opa_q;
          end
          OP_HALF: begin
            wr_en   = 1'b1;
            wr_data = half_val;
            if (h_over) sat_d = 1'b1;
            if (rd_q == R_CX) begin
              cx_d = half_val[CTR_W-1:0];
            end else begin
              cy_d = half_val[CTR_W-1:0];
            end
          end
          OP_ROOT: begin
            if (|opa_q[WIDE_W-1:64]) begin
              rad_d = '1;
              sat_d = 1'b1;
            end else begin
              a_d    = opa_q;
              b_d    = '0;
              acc_d  = '0;
              cnt_d  = ITER_W'(ROOT_W);
              ph_d   = PH_RUN;
              done_d = 1'b0;
            end
          end
          OP_FAIL: begin
            cx_d  = '0;
            cy_d  = '0;
            rad_d = '0;
            sat_d = 1'b1;
          end
          default: ;
        endcase
      end
      PH_RUN: begin
        cnt_d = cnt_q - ITER_W'(1);
        case (op_q)
          OP_MUL: begin
            acc_d = {1'b0, mul_acc};
            a_d   = {a_q[WIDE_W-2:0], 1'b0};
            b_d   = {1'b0, b_q[WIDE_W-1:1]};
          end
          OP_DIV: begin
            acc_d = div_rem;
            a_d   = div_a;
          end
          default: begin
            acc_d = {{(WIDE_W+1-SQ_W){1'b0}}, sq_rem};
            a_d   = {a_q[WIDE_W-3:0], 2'b00};
            b_d   = sq_root;
          end
        endcase
        if (cnt_q == ITER_W'(1)) begin
          ph_d   = PH_IDLE;
          done_d = 1'b1;
          case (op_q)
            OP_MUL: begin
              wr_en   = 1'b1;
              wr_data = mul_acc;
            end
            OP_DIV: begin
              wr_en   = 1'b1;
              wr_data = div_a;
            end
            default: begin
              // rounded root saturates at the top of the radius range
              if (rad_r[ROOT_W-1]) begin
                rad_d = '1;
                sat_d = 1'b1;
              end else begin
                rad_d = rad_r[RAD_W-1:0];
              end
            end
          endcase
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  assign nonpos_d = wr_en ? (wr_data[WIDE_W-1] || (wr_data == '0)) : nonpos_q;

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) rf_q[rd_q] <= wr_data;
    if (cmd_i.valid) begin
      opa_q <= rf_q[cmd_i.instr.ra];
      opb_q <= rf_q[cmd_i.instr.rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      done_q   <= 1'b0;
      nonpos_q <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      ph_q     <= ph_d;
      done_q   <= done_d;
      nonpos_q <= nonpos_d;
      sat_q    <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid) begin
      op_q <= cmd_i.instr.op;
      rd_q <= cmd_i.instr.rd;
    end
    cnt_q <= cnt_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    rad_q <= rad_d;
  end

  assign status_o.done   = done_q;
  assign status_o.nonpos = nonpos_q;
  assign center_x_o      = cx_q;
  assign center_y_o      = cy_q;
  assign radius_o        = rad_q;
  assign fit_failed_o    = sat_q;

endmodule

/* design/clfit_ctrl.sv */
// solve sequencer: steps through the microprogram and drives the datapath
// depends on clfit_pkg
`timescale 1ns / 1ps

module clfit_ctrl import clfit_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       last_point_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       clear_o,
  output logic       result_valid_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_DRAIN, ST_ISSUE, ST_WAIT, ST_FINISH} state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic [1:0]      drain_q;
  logic            busy_q, clear_q, rv_q;
  dp_cmd_t         cmd_q;
  instr_t          cur;

  assign cur = prog_rom(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      drain_q <= '0;
      busy_q  <= 1'b0;
      clear_q <= 1'b0;
      rv_q    <= 1'b0;
      cmd_q   <= '0;
    end else begin
      cmd_q.valid <= 1'b0;
      clear_q     <= 1'b0;
      rv_q        <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i && last_point_i) begin
            busy_q  <= 1'b1;
            drain_q <= '0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // let the last point reach the sums
          drain_q <= drain_q + 2'd1;
          if (drain_q == 2'd2) begin
            pc_q    <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          case (cur.op)
            OP_BRNP: begin
              pc_q <= status_i.nonpos ? PC_FAIL : (pc_q + PC_W'(1));
            end
            OP_END: begin
              rv_q    <= 1'b1;
              clear_q <= 1'b1;
              state_q <= ST_FINISH;
            end
            default: begin
              cmd_q.valid <= 1'b1;
              cmd_q.instr <= cur;
              state_q     <= ST_WAIT;
            end
          endcase
        end
        ST_WAIT: begin
          if (status_i.done) begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= ST_ISSUE;
          end
        end
        ST_FINISH: begin
          busy_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cmd_o          = cmd_q;
  assign busy_o         = busy_q;
  assign clear_o        = clear_q;
  assign result_valid_o = rv_q;

endmodule

/* design/circle_fit_least_squares_core.sv */
// top level of the algebraic circle fit core
// depends on clfit_pkg, clfit_accum, clfit_dp, clfit_ctrl and the assertion header
`timescale 1ns / 1ps

// usage
// - a point transfer happens on a rising edge with start high and busy low;
//   point_x_i / point_y_i carry the hit, last_point_i closes the track
// - while no last point is seen busy stays low and one point per cycle
//   is taken into the running sums (up to MAX_POINTS) through a three-stage pipeline
// - a last point raises busy on the next cycle; the sums then drain and
//   the solve runs on a shared bit-serial unit (144 steps per wide multiply
//   or divide, 32 per root); the program holds 21 multiplies and 3 divides
// - the result is shown for exactly one cycle with result_valid_o high;
//   the receiver cannot stall, so that cycle is the transfer
// - busy falls the cycle after the strobe; the sums are cleared by then
// - fit_failed_o flags a singular system (outputs zero) or saturation
// - reset (rst_ni low, asynchronous) clears the sums, count and sequencer

module circle_fit_least_squares_core import clfit_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [15:0]      point_x_i,
  input  logic signed [15:0]      point_y_i,
  input  logic                    last_point_i,
  output logic                    result_valid_o,
  output logic signed [CTR_W-1:0] center_x_o,
  output logic signed [CTR_W-1:0] center_y_o,
  output logic [RAD_W-1:0]        radius_o,
  output logic                    fit_failed_o
);

`include "circle_fit_least_squares_core_assert.svh"

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = COORD_BITS + CNT_W;
  localparam int SXX_W = 2 * COORD_BITS + CNT_W;
  localparam int SZ_W  = 2 * COORD_BITS + 1 + CNT_W;
  localparam int SXZ_W = 3 * COORD_BITS + 1 + CNT_W;

  logic              accept;
  logic              clear;
  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [CNT_W-1:0]  count;
  logic [SX_W-1:0]   sum_x, sum_y;
  logic [SXX_W-1:0]  sum_xx, sum_xy, sum_yy;
  logic [SXZ_W-1:0]  sum_xz, sum_yz;
  logic [SZ_W-1:0]   sum_z;

  // a point transfer
  assign accept = start && !busy;

  clfit_accum #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .clear_i  (clear),
    .count_o  (count),
    .sum_x_o  (sum_x),
    .sum_y_o  (sum_y),
    .sum_xx_o (sum_xx),
    .sum_xy_o (sum_xy),
    .sum_yy_o (sum_yy),
    .sum_xz_o (sum_xz),
    .sum_yz_o (sum_yz),
    .sum_z_o  (sum_z)
  );

  // sequencer owns busy; it only sees last_point_i on a point transfer
  clfit_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept),
    .last_point_i  (last_point_i),
    .status_i      (status),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .clear_o       (clear),
    .result_valid_o(result_valid_o)
  );

  clfit_dp #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .count_i     (count),
    .sum_x_i     (sum_x),
    .sum_y_i     (sum_y),
    .sum_xx_i    (sum_xx),
    .sum_xy_i    (sum_xy),
    .sum_yy_i    (sum_yy),
    .sum_xz_i    (sum_xz),
    .sum_yz_i    (sum_yz),
    .sum_z_i     (sum_z),
    .center_x_o  (center_x_o),
    .center_y_o  (center_y_o),
    .radius_o    (radius_o),
    .fit_failed_o(fit_failed_o)
  );

  // the result strobe only appears inside a solve, for one cycle
  `CLFIT_ASSERT_IMP(a_strobe_in_busy, clk_i, rst_ni, result_valid_o, busy)
  `CLFIT_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)
  // a last point locks the input out from the next cycle
  `CLFIT_ASSERT_NXT(a_last_locks, clk_i, rst_ni, start && !busy && last_point_i, busy)
  // busy is only released right after a result
  `CLFIT_ASSERT_IMP(a_release_after_result, clk_i, rst_ni, $fell(busy), $past(result_valid_o))

endmodule

/* test/tb_circle_fit_least_squares_core.sv */
// testbench for circle_fit_least_squares_core: drives point tracks, predicts each fit
// depends on clfit_pkg and circle_fit_least_squares_core
`timescale 1ns / 1ps

module tb_circle_fit_least_squares_core;
  import clfit_pkg::*;

  localparam int MAX_PTS   = 1024;
  localparam int WDOG_MAX  = 40000;
  localparam int N_ITEMS   = 700;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [RAD_W-1:0]        rad;
    logic                    failed;
  } fit_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [15:0]      point_x_i = '0;
  logic signed [15:0]      point_y_i = '0;
  logic                    last_point_i = 1'b0;
  logic                    result_valid_o;
  logic signed [CTR_W-1:0] center_x_o;
  logic signed [CTR_W-1:0] center_y_o;
  logic [RAD_W-1:0]        radius_o;
  logic                    fit_failed_o;

  always #4 clk_i = ~clk_i;

  circle_fit_least_squares_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .point_x_i, .point_y_i, .last_point_i,
    .result_valid_o, .center_x_o, .center_y_o, .radius_o, .fit_failed_o
  );

  // running sums and the queue of fits still to come out
  class fit_scoreboard;
    longint n_pts, s_x, s_y, s_xx, s_xy, s_yy, s_xz, s_yz, s_z;
    fit_t   fits_due[$];
    int     n_errors;
    bit     sat;

    function void clear_sums();
      n_pts = 0; s_x = 0; s_y = 0; s_xx = 0; s_xy = 0;
      s_yy = 0; s_xz = 0; s_yz = 0; s_z = 0;
    endfunction

    function new();
      clear_sums();
      n_errors = 0;
    endfunction

    function bit [63:0] root64(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // num / (2 det) rounded half away from zero, clamped to 32-bit signed
    function wide_t half_ratio(wide_t num, wide_t det);
      bit    neg;
      wide_t mag, q, lim;
      neg = num < wide_t'(0);
      mag = neg ? -num : num;
      q   = (mag + det) / (det + det);
      lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
      if (q > lim) begin
        q = lim;
        sat = 1'b1;
      end
      return neg ? -q : q;
    endfunction

    function void note_point(logic signed [15:0] px, logic signed [15:0] py, logic last);
      longint x, y, z;
      wide_t n, cxx, cxy, cyy, cxz, cyz, det, dn, en, wcx, wcy, q, v;
      fit_t f;
      x = longint'(px); y = longint'(py); z = x * x + y * y;
      if (n_pts < MAX_PTS) begin
        n_pts++;
        s_x += x; s_y += y; s_xx += x * x; s_xy += x * y; s_yy += y * y;
        s_xz += x * z; s_yz += y * z; s_z += z;
      end
      if (!last) return;
      n   = wide_t'(n_pts);
      cxx = n * wide_t'(s_xx) - wide_t'(s_x) * wide_t'(s_x);
      cxy = n * wide_t'(s_xy) - wide_t'(s_x) * wide_t'(s_y);
      cyy = n * wide_t'(s_yy) - wide_t'(s_y) * wide_t'(s_y);
      cxz = n * wide_t'(s_xz) - wide_t'(s_x) * wide_t'(s_z);
      cyz = n * wide_t'(s_yz) - wide_t'(s_y) * wide_t'(s_z);
      det = cxx * cyy - cxy * cxy;
      f = '{cx: '0, cy: '0, rad: '0, failed: 1'b1};
      if (det > wide_t'(0) && n_pts != 0) begin
        sat = 1'b0;
        dn  = cxz * cyy - cxy * cyz;
        en  = cxx * cyz - cxy * cxz;
        wcx = half_ratio(dn, det);
        wcy = half_ratio(en, det);
        // sum of squared distances from the rounded centre
        q = wide_t'(s_z) - wide_t'(2) * (wcx * wide_t'(s_x) + wcy * wide_t'(s_y))
            + n * (wcx * wcx + wcy * wcy);
        if (q < wide_t'(0)) q = '0;
        v = (q * wide_t'(4)) / n;
        f.cx = wcx[31:0];
        f.cy = wcy[31:0];
        if ((v >> 64) != wide_t'(0)) begin
          f.rad = '1;
          sat   = 1'b1;
        end else begin
          v = wide_t'((root64(v[63:0]) + 64'd1) >> 1);
          if (v > wide_t'(64'h7FFF_FFFF)) begin
            f.rad = '1;
            sat   = 1'b1;
          end else begin
            f.rad = v[30:0];
          end
        end
        f.failed = sat;
      end
      fits_due.push_back(f);
      clear_sums();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      n_errors++;
    endtask

    task check_fit(fit_t got);
      fit_t want;
      if (fits_due.size() == 0) begin
        report_mismatch("fits outstanding", 1, 0);
        return;
      end
      want = fits_due.pop_front();
      if (got.cx !== want.cx) report_mismatch("center_x", got.cx, want.cx);
      if (got.cy !== want.cy) report_mismatch("center_y", got.cy, want.cy);
      if (got.rad !== want.rad) report_mismatch("radius", got.rad, want.rad);
      if (got.failed !== want.failed) report_mismatch("fit_failed", got.failed, want.failed);
    endtask
  endclass

  fit_scoreboard sb = new();
  bit            idle_on = 1'b1;
  int            n_sent = 0;

  // result strobe is a transfer on its own, no back-pressure possible
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_fit('{cx: center_x_o, cy: center_y_o, rad: radius_o, failed: fit_failed_o});
  end

  // watchdog: cycles with neither a point nor a fit transfer
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("tb_circle_fit_least_squares_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one point transfer, with an occasional idle burst ahead of it
  task send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start        <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (busy);
    sb.note_point(x, y, last);
    n_sent++;
  endtask

  function automatic logic signed [15:0] clip16(real v);
    if (v > 32767.0) return 16'sh7FFF;
    if (v < -32768.0) return 16'sh8000;
    return 16'($rtoi(v));
  endfunction

  // points on a random circle with a little jitter
  task send_circle_track(int len);
    real ox, oy, r, t;
    ox = $itor($signed($urandom_range(0, 40000))) - 20000.0;
    oy = $itor($signed($urandom_range(0, 40000))) - 20000.0;
    r  = $itor($urandom_range(1, 20000));
    for (int i = 0; i < len; i++) begin
      t = $itor($urandom_range(0, 62831)) / 10000.0;
      send_point(clip16(ox + r * $cos(t) + $itor($urandom_range(0, 8)) - 4.0),
                 clip16(oy + r * $sin(t) + $itor($urandom_range(0, 8)) - 4.0),
                 i == len - 1);
    end
  endtask

  initial begin
    int len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: singular tracks of one, two and three collinear points
    send_point(16'sh0100, 16'sh0200, 1'b1);
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, 16'sh8000, 1'b1);
    send_point(-16'sd100, -16'sd100, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd100, 16'sd100, 1'b1);
    // extreme corners make a proper circle
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    // nearly collinear: centre far away, may saturate
    send_point(16'sh8000, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sh7FFF, 16'sd0, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    // small exact circle
    send_point(16'sd256, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd256, 1'b0);
    send_point(-16'sd256, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd256, 1'b1);

    while (n_sent < N_ITEMS) begin
      if (n_sent > N_ITEMS - 60) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 5);
          for (int i = 0; i < len; i++)
            send_point(16'($urandom()), 16'($urandom()), i == len - 1);
        end
        1: begin
          // collinear, singular unless something rounds oddly
          len = $urandom_range(2, 6);
          for (int i = 0; i < len; i++)
            send_point(16'(i * 1000), 16'(i * 1000 + 7), i == len - 1);
        end
        default: send_circle_track($urandom_range(3, 14));
      endcase
    end
    start <= 1'b0;

    while (sb.fits_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("tb_circle_fit_least_squares_core passed");
    end else begin
      $display("tb_circle_fit_least_squares_core failed");
    end
    $finish;
  end

endmodule
